[hw/rtl/dfu_pkg.sv]
// Shared types and constants for the multichannel dimmer fade unit.
// No dependencies; all other files but the two interfaces reference this package by scoped name.
package dfu_pkg;

  localparam int LVL_W      = 16;
  localparam int FT_W       = 8;
  localparam int CH_W       = 2;
  localparam int STEP_W     = 14;
  localparam int DEN_W      = FT_W + 2;
  localparam int DIV_CNT_W  = $clog2(LVL_W);
  localparam int FIFO_DEPTH = 4;

  localparam logic [LVL_W-1:0] FULL_SCALE = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_FADE     = 2'd0,
    REQ_EXEC_ONE = 2'd1,
    REQ_EXEC_ALL = 2'd2,
    REQ_TICK     = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    OP_FADE_RUN,
    OP_FADE_HOLD,
    OP_START_ONE,
    OP_START_ALL,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CH_W-1:0]  ch;
    logic [FT_W-1:0]  fade_time;
    logic [LVL_W-1:0] target;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_DIV_DONE,
    S_TICK
  } state_t;

endpackage

[hw/rtl/dfu_in_if.sv]
// Request channel of the dimmer fade unit: valid/ready plus request payload.
// No dependencies.
interface dfu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [1:0]  channel;
  logic [7:0]  fade_time;
  logic [15:0] target_level;
  logic        wait_for_execute;

  modport source (output valid, req_type, channel, fade_time, target_level,
                  wait_for_execute, input ready);
  modport sink   (input valid, req_type, channel, fade_time, target_level,
                  wait_for_execute, output ready);
endinterface

[hw/rtl/dfu_out_if.sv]
// Result channel of the dimmer fade unit: valid/ready plus per-channel report.
// No dependencies.
interface dfu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_channel;
  logic [15:0] level;
  logic [15:0] compare_value;
  logic        last;

  modport source (output valid, out_channel, level, compare_value, last,
                  input ready);
  modport sink   (input valid, out_channel, level, compare_value, last,
                  output ready);
endinterface

[hw/rtl/multichannel_dimmer_fade_unit.sv]
// Multichannel dimmer fade unit, top level: front end, command queue, fade engine.
// A request is registered in the command queue before it reaches the engine. A start with
// fade time 0 pops and then loads (jumps) the channel; a held fade only pops; a nonzero
// fade time runs load, serial divide and divide-done per channel, and execute-all walks
// every channel in turn. A tick walks all channels, one result per cycle while ready is
// high; requests queue 4 deep meanwhile. Synchronous reset clears all channel state to zero.
module multichannel_dimmer_fade_unit #(
  parameter int CHANNELS = 4
) (
  input logic        clk,
  input logic        rst,
  dfu_in_if.sink     cmd_in,
  dfu_out_if.source  res_out
);

  logic          push;
  logic          full;
  logic          pop;
  logic          head_valid;
  dfu_pkg::cmd_t push_cmd;
  dfu_pkg::cmd_t head;

  dfu_front #(.CHANNELS(CHANNELS)) u_front (
    .cmd_in    (cmd_in),
    .fifo_full (full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  dfu_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  dfu_back #(.CHANNELS(CHANNELS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_out    (res_out)
  );

endmodule

[hw/rtl/dfu_front.sv]
// Front end: accepts requests, drops out-of-range channel commands and
// classifies the rest into queue commands. Depends on dfu_pkg, dfu_in_if.
module dfu_front #(
  parameter int CHANNELS = 4
) (
  dfu_in_if.sink         cmd_in,
  input  logic           fifo_full,
  output logic           push,
  output dfu_pkg::cmd_t  push_cmd
);

  logic ch_ok;
  logic drop;

  assign ch_ok        = {3'b000, cmd_in.channel} < 5'(CHANNELS);
  assign cmd_in.ready = !fifo_full;

  always_comb begin
    push_cmd.ch        = cmd_in.channel;
    push_cmd.fade_time = cmd_in.fade_time;
    push_cmd.target    = cmd_in.target_level;
    push_cmd.op        = dfu_pkg::OP_TICK;
    drop               = 1'b0;
    unique case (dfu_pkg::req_t'(cmd_in.req_type))
      dfu_pkg::REQ_FADE: begin
        push_cmd.op = cmd_in.wait_for_execute ? dfu_pkg::OP_FADE_HOLD
                                              : dfu_pkg::OP_FADE_RUN;
        drop        = !ch_ok;
      end
      dfu_pkg::REQ_EXEC_ONE: begin
        push_cmd.op = dfu_pkg::OP_START_ONE;
        drop        = !ch_ok;
      end
      dfu_pkg::REQ_EXEC_ALL: push_cmd.op = dfu_pkg::OP_START_ALL;
      dfu_pkg::REQ_TICK:     push_cmd.op = dfu_pkg::OP_TICK;
      default:               push_cmd.op = dfu_pkg::OP_TICK;
    endcase
  end

  assign push = cmd_in.valid && cmd_in.ready && !drop;

endmodule

[hw/rtl/dfu_cmd_fifo.sv]
// Short command queue between front end and fade engine.
// Depends on dfu_pkg.
module dfu_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dfu_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output dfu_pkg::cmd_t  head
);

  localparam int PTR_W = $clog2(dfu_pkg::FIFO_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  dfu_pkg::cmd_t    mem [dfu_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(dfu_pkg::FIFO_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("command queue overrun");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> !pop) else $error("command queue underrun");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(dfu_pkg::FIFO_DEPTH)) else $error("queue count out of range");

endmodule

[hw/rtl/dfu_back.sv]
// Fade engine: per-channel level state, bit-serial step divider and tick walk
// that reports every channel through an output register. Depends on dfu_pkg,
// dfu_out_if.
module dfu_back #(
  parameter int CHANNELS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  dfu_pkg::cmd_t  head,
  output logic           pop,
  dfu_out_if.source      res_out
);

  localparam int LW    = dfu_pkg::LVL_W;
  localparam int SW    = dfu_pkg::STEP_W;
  localparam int DW    = dfu_pkg::DEN_W;
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_X = (IDX_W < 2) ? 2 : IDX_W;

  dfu_pkg::state_t state, state_next;

  logic [LW-1:0]            cur_lvl  [CHANNELS];
  logic [LW-1:0]            dst_lvl  [CHANNELS];
  logic [dfu_pkg::FT_W-1:0] fade_t   [CHANNELS];
  logic [SW-1:0]            step_amt [CHANNELS];

  logic [IDX_W-1:0] idx;
  logic [IDX_X-1:0] idx_x;
  logic             all_mode;

  logic [LW-1:0]                 div_num;
  logic [DW-1:0]                 div_rem;
  logic [DW-1:0]                 div_den;
  logic [dfu_pkg::DIV_CNT_W-1:0] div_cnt;

  logic [LW-1:0]            rd_cur;
  logic [LW-1:0]            rd_dst;
  logic [dfu_pkg::FT_W-1:0] rd_ft;
  logic [SW-1:0]            rd_step;

  logic          idx_last;
  logic          more;
  logic          out_free;
  logic [LW-1:0] diff;
  logic [DW:0]   div_sh;
  logic [DW:0]   div_sub;
  logic          div_ge;
  logic [SW-1:0] step_new;
  logic [LW-1:0] adv_lvl;
  logic [SW-1:0] adv_step;
  logic [LW-1:0] headroom;
  logic [LW-1:0] up_sum;
  logic [LW-1:0] dn_dif;
  logic [IDX_W-1:0] head_idx;

  logic fade_wr, jump_wr, div_start, div_run, step_wr, adv_wr, idx_inc;

  assign rd_cur   = cur_lvl[idx];
  assign rd_dst   = dst_lvl[idx];
  assign rd_ft    = fade_t[idx];
  assign rd_step  = step_amt[idx];
  assign idx_x    = IDX_X'(idx);
  assign head_idx = IDX_W'(head.ch);

  assign idx_last = idx == IDX_W'(CHANNELS - 1);
  assign more     = all_mode && !idx_last;
  assign out_free = !res_out.valid || res_out.ready;

  assign diff     = (rd_dst > rd_cur) ? (rd_dst - rd_cur) : (rd_cur - rd_dst);
  assign div_sh   = {div_rem, div_num[LW-1]};
  assign div_sub  = div_sh - {1'b0, div_den};
  assign div_ge   = div_sh >= {1'b0, div_den};
  // divisor is at least 4, so the quotient fits the step width
  assign step_new = (div_num == '0) ? SW'(1) : div_num[SW-1:0];

  assign headroom = dfu_pkg::FULL_SCALE - rd_cur;
  assign up_sum   = rd_cur + LW'(rd_step);
  assign dn_dif   = rd_cur - LW'(rd_step);

  always_comb begin
    adv_lvl  = rd_cur;
    adv_step = rd_step;
    if (rd_step != '0) begin
      if (rd_cur < rd_dst) begin
        if (headroom > LW'(rd_step) && up_sum <= rd_dst) begin
          adv_lvl = up_sum;
        end else begin
          adv_lvl  = rd_dst;
          adv_step = '0;
        end
      end else if (rd_cur > rd_dst) begin
        if (rd_cur > LW'(rd_step) && dn_dif >= rd_dst) begin
          adv_lvl = dn_dif;
        end else begin
          adv_lvl  = rd_dst;
          adv_step = '0;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dfu_pkg::S_IDLE: begin
        if (head_valid) begin
          case (head.op) inside
            dfu_pkg::OP_FADE_RUN, dfu_pkg::OP_START_ONE,
            dfu_pkg::OP_START_ALL:  state_next = dfu_pkg::S_LOAD;
            dfu_pkg::OP_TICK:       state_next = dfu_pkg::S_TICK;
            default:                state_next = dfu_pkg::S_IDLE;
          endcase
        end
      end
      dfu_pkg::S_LOAD: begin
        if (rd_ft != '0)  state_next = dfu_pkg::S_DIV;
        else if (!more)   state_next = dfu_pkg::S_IDLE;
      end
      dfu_pkg::S_DIV: begin
        if (div_cnt == '0) state_next = dfu_pkg::S_DIV_DONE;
      end
      dfu_pkg::S_DIV_DONE: begin
        state_next = more ? dfu_pkg::S_LOAD : dfu_pkg::S_IDLE;
      end
      dfu_pkg::S_TICK: begin
        if (out_free && idx_last) state_next = dfu_pkg::S_IDLE;
      end
      default: state_next = dfu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    fade_wr   = 1'b0;
    jump_wr   = 1'b0;
    div_start = 1'b0;
    div_run   = 1'b0;
    step_wr   = 1'b0;
    adv_wr    = 1'b0;
    unique case (state)
      dfu_pkg::S_IDLE: begin
        pop     = head_valid;
        fade_wr = head_valid &&
                  (head.op inside {dfu_pkg::OP_FADE_RUN, dfu_pkg::OP_FADE_HOLD});
      end
      dfu_pkg::S_LOAD: begin
        jump_wr   = rd_ft == '0;
        div_start = rd_ft != '0;
      end
      dfu_pkg::S_DIV:      div_run = 1'b1;
      dfu_pkg::S_DIV_DONE: step_wr = 1'b1;
      dfu_pkg::S_TICK:     adv_wr  = out_free;
      default: ;
    endcase
    idx_inc = ((jump_wr || step_wr) && more) || (adv_wr && !idx_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= dfu_pkg::S_IDLE;
      idx           <= '0;
      all_mode      <= 1'b0;
      res_out.valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        cur_lvl[i]  <= '0;
        dst_lvl[i]  <= '0;
        fade_t[i]   <= '0;
        step_amt[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (pop) begin
        all_mode <= head.op == dfu_pkg::OP_START_ALL;
        idx      <= (head.op == dfu_pkg::OP_START_ALL || head.op == dfu_pkg::OP_TICK)
                    ? '0 : head_idx;
      end else if (idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (fade_wr) begin
        dst_lvl[head_idx]  <= head.target;
        fade_t[head_idx]   <= head.fade_time;
        step_amt[head_idx] <= '0;
      end
      if (jump_wr) begin
        cur_lvl[idx]  <= rd_dst;
        step_amt[idx] <= '0;
      end
      if (step_wr) step_amt[idx] <= step_new;
      if (adv_wr) begin
        cur_lvl[idx]  <= adv_lvl;
        step_amt[idx] <= adv_step;
        res_out.valid <= 1'b1;
      end else if (res_out.ready) begin
        res_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_num <= diff;
      div_rem <= '0;
      div_den <= {rd_ft, 2'b00};
      div_cnt <= '1;
    end else if (div_run) begin
      div_num <= {div_num[LW-2:0], div_ge};
      div_rem <= div_ge ? div_sub[DW-1:0] : div_sh[DW-1:0];
      div_cnt <= div_cnt - 1'b1;
    end
    if (adv_wr) begin
      res_out.out_channel   <= idx_x[1:0];
      res_out.level         <= adv_lvl;
      res_out.compare_value <= dfu_pkg::FULL_SCALE - adv_lvl;
      res_out.last          <= idx_last;
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == dfu_pkg::S_DIV |-> div_den != '0) else $error("zero divisor");
  a_step_fits: assert property (@(posedge clk) disable iff (rst)
    state == dfu_pkg::S_DIV_DONE |-> div_num[LW-1:SW] == '0)
    else $error("step overflows its width");
  a_tick_emits: assert property (@(posedge clk) disable iff (rst)
    adv_wr |=> res_out.valid) else $error("tick result not presented");
  a_tick_single: assert property (@(posedge clk) disable iff (rst)
    state == dfu_pkg::S_TICK |-> !all_mode) else $error("tick in start-all mode");

endmodule

[bench/tb_top.sv]
// Self-checking bench for multichannel_dimmer_fade_unit: drives fade, execute and tick
// requests with random idling on both sides and checks every per-channel level report.
// Depends on dfu_pkg, dfu_in_if, dfu_out_if and the RTL top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_CH = 4;
  localparam int STALL_MAX = 18;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_REQUESTS = 350;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    bit [1:0]  ch;
    bit [15:0] level;
    bit [15:0] cmp;
    bit        last;
  } level_report_t;

  class fade_scoreboard;
    bit [15:0]     level_now [N_CH];
    bit [15:0]     level_goal[N_CH];
    bit [7:0]      fade_units[N_CH];
    bit [13:0]     ramp_step [N_CH];
    level_report_t pending_reports[$];
    int            errors;

    function void start_fade(int unsigned c);
      int unsigned diff;
      int unsigned stp;
      if (fade_units[c] == 0) begin
        ramp_step[c] = '0;
        level_now[c] = level_goal[c];
        return;
      end
      diff = (level_goal[c] > level_now[c]) ? level_goal[c] - level_now[c]
                                            : level_now[c] - level_goal[c];
      stp = diff / (fade_units[c] * 4);
      if (stp < 1) stp = 1;
      ramp_step[c] = stp[13:0];
    endfunction

    function void note_request(dfu_pkg::req_t kind, bit [1:0] ch, bit [7:0] ft,
                               bit [15:0] tgt, bit hold);
      int unsigned cur;
      int unsigned dst;
      int unsigned stp;
      level_report_t rep;
      case (kind)
        dfu_pkg::REQ_FADE: begin
          level_goal[ch] = tgt;
          fade_units[ch] = ft;
          ramp_step[ch] = '0;
          if (!hold) start_fade(ch);
        end
        dfu_pkg::REQ_EXEC_ONE: begin
          start_fade(ch);
        end
        dfu_pkg::REQ_EXEC_ALL: begin
          for (int c = 0; c < N_CH; c++) start_fade(c);
        end
        default: begin
          for (int c = 0; c < N_CH; c++) begin
            cur = level_now[c];
            dst = level_goal[c];
            stp = ramp_step[c];
            if (stp != 0) begin
              if (cur < dst) begin
                if ((dfu_pkg::FULL_SCALE - cur) > stp) begin
                  cur += stp;
                  if (cur > dst) begin
                    cur = dst;
                    stp = 0;
                  end
                end else begin
                  cur = dst;
                  stp = 0;
                end
              end else if (cur > dst) begin
                if (cur > stp) begin
                  cur -= stp;
                  if (cur < dst) begin
                    cur = dst;
                    stp = 0;
                  end
                end else begin
                  cur = dst;
                  stp = 0;
                end
              end
            end
            level_now[c] = cur[15:0];
            ramp_step[c] = stp[13:0];
            rep.ch = c[1:0];
            rep.level = cur[15:0];
            rep.cmp = dfu_pkg::FULL_SCALE - cur[15:0];
            rep.last = (c == N_CH - 1);
            pending_reports.push_back(rep);
          end
        end
      endcase
    endfunction

    function void compare_field(string name, bit [15:0] exp_v, bit [15:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_report(bit [1:0] ch, bit [15:0] lvl, bit [15:0] cmp, bit lst);
      level_report_t exp_r;
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected report: expected none actual ch=%0d level=%h cmp=%h last=%0d",
                 $time, ch, lvl, cmp, lst);
        errors++;
        return;
      end
      exp_r = pending_reports.pop_front();
      compare_field("out_channel", 16'(exp_r.ch), 16'(ch));
      compare_field("level", exp_r.level, lvl);
      compare_field("compare_value", exp_r.cmp, cmp);
      compare_field("last", 16'(exp_r.last), 16'(lst));
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   send_steady;
  bit   recv_steady;
  int   idle_cycles;

  fade_scoreboard sb = new();

  dfu_in_if  cmd_if ();
  dfu_out_if res_if ();

  multichannel_dimmer_fade_unit #(.CHANNELS(N_CH)) u_top (
    .clk     (clk),
    .rst     (rst),
    .cmd_in  (cmd_if),
    .res_out (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_request(dfu_pkg::req_t kind, bit [1:0] ch, bit [7:0] ft,
                              bit [15:0] tgt, bit hold);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid            <= 1'b1;
    cmd_if.req_type         <= kind;
    cmd_if.channel          <= ch;
    cmd_if.fade_time        <= ft;
    cmd_if.target_level     <= tgt;
    cmd_if.wait_for_execute <= hold;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    sb.note_request(kind, ch, ft, tgt, hold);
  endtask

  task automatic send_tick();
    send_request(dfu_pkg::REQ_TICK, 2'($urandom), 8'($urandom), 16'($urandom),
                 1'($urandom));
  endtask

  // result side: random back-pressure per report
  initial begin
    int stall;
    res_if.ready <= 1'b0;
    forever begin
      if ($urandom_range(0, 24) == 0) recv_steady = !recv_steady;
      stall = recv_steady ? 0 : $urandom_range(0, STALL_MAX);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      sb.check_report(res_if.out_channel, res_if.level, res_if.compare_value, res_if.last);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[multichannel_dimmer_fade_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dfu_pkg::req_t kind;
    int            pick;
    int            r;
    bit [7:0]      ft;
    bit [15:0]     tgt;
    rst                     <= 1'b1;
    cmd_if.valid            <= 1'b0;
    cmd_if.req_type         <= dfu_pkg::REQ_TICK;
    cmd_if.channel          <= '0;
    cmd_if.fade_time        <= '0;
    cmd_if.target_level     <= '0;
    cmd_if.wait_for_execute <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: jump, step floor, exact landing, overshoot, guards, held fades
    send_tick();
    send_request(dfu_pkg::REQ_FADE, 2'd0, 8'd0, 16'hFFFF, 1'b0);
    send_request(dfu_pkg::REQ_FADE, 2'd1, 8'd1, 16'd40003, 1'b0);
    send_request(dfu_pkg::REQ_FADE, 2'd2, 8'd1, 16'd3, 1'b0);
    send_request(dfu_pkg::REQ_FADE, 2'd3, 8'd1, 16'hFFFF, 1'b1);
    repeat (3) send_tick();
    send_request(dfu_pkg::REQ_EXEC_ONE, 2'd3, 8'hFF, 16'h0000, 1'b0);
    send_request(dfu_pkg::REQ_FADE, 2'd0, 8'd1, 16'h0000, 1'b1);
    send_request(dfu_pkg::REQ_EXEC_ALL, 2'd0, 8'd0, 16'hFFFF, 1'b1);
    repeat (5) send_tick();
    send_request(dfu_pkg::REQ_FADE, 2'd1, 8'hFF, 16'h0000, 1'b0);
    send_request(dfu_pkg::REQ_FADE, 2'd2, 8'hAA, 16'h5555, 1'b1);
    send_request(dfu_pkg::REQ_EXEC_ONE, 2'd2, 8'h55, 16'hAAAA, 1'b0);
    repeat (2) send_tick();

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if ($urandom_range(0, 24) == 0) send_steady = !send_steady;
      pick = $urandom_range(0, 99);
      r = $urandom_range(0, 9);
      ft = (r == 0) ? 8'd0 : (r < 8) ? 8'($urandom_range(1, 6)) : 8'($urandom);
      r = $urandom_range(0, 9);
      tgt = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
      if (pick < 55) kind = dfu_pkg::REQ_TICK;
      else if (pick < 85) kind = dfu_pkg::REQ_FADE;
      else if (pick < 93) kind = dfu_pkg::REQ_EXEC_ONE;
      else kind = dfu_pkg::REQ_EXEC_ALL;
      send_request(kind, 2'($urandom), ft, tgt, $urandom_range(0, 3) == 0);
    end
    cmd_if.valid <= 1'b0;

    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[multichannel_dimmer_fade_unit] OK");
    end else begin
      $display("[multichannel_dimmer_fade_unit] ERROR");
    end
    $finish;
  end
endmodule
